### rtl/core/bia_pkg.sv
package bia_pkg;

    // Field widths and fixed values
    localparam int ID_W          = 12;
    localparam int BYTE_W        = 8;
    localparam int BIT_POS_W     = 3;
    localparam int BYTE_IDX_W    = ID_W - BIT_POS_W;
    localparam int MAP_BYTES_DEF = 512;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] TOP_BIT   = 8'h80;

    // Request codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REL_WR,
        ST_ALC_CHK
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;    // write zero at the clear index and advance
        logic load_rel;      // latch release id, read its byte
        logic load_alloc;    // start scan at the hint, read that byte
        logic rel_write;     // clear the released bit, emit release result
        logic alc_hit;       // set the lowest clear bit, emit the id
        logic scan_step;     // advance scan, read the next byte
        logic emit_release;  // emit release result without touching the map
        logic emit_full;     // emit the full result, mark the map full
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic rel_in_range;
        logic all_full;
        logic byte_full;
        logic scan_last;
    } status_t;

    // One-hot of the lowest clear bit of a byte
    function automatic logic [BYTE_W-1:0] lowest_clear(input logic [BYTE_W-1:0] m);
        return (~m) & (m + BYTE_W'(1));
    endfunction

    // Position of the single set bit of a one-hot byte; 0 if none
    function automatic logic [BIT_POS_W-1:0] onehot_pos(input logic [BYTE_W-1:0] oh);
        logic [BIT_POS_W-1:0] pos;
        logic [BYTE_W-1:0]    probe;
        pos   = '0;
        probe = TOP_BIT;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if ((oh & probe) != '0)
            begin
                pos = BIT_POS_W'(i);
            end
            probe = probe >> 1;
        end
        return pos;
    endfunction

endpackage

### rtl/core/bia_ram.sv
module bia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/bia_ctrl.sv
module bia_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             op,
    input  bia_pkg::status_t status,
    output logic             busy,
    output bia_pkg::cmd_t    cmd
);

    import bia_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_RELEASE)
                    begin
                        if (status.rel_in_range)
                        begin
                            state_next = ST_REL_WR;
                        end
                    end
                    else if (!status.all_full)
                    begin
                        state_next = ST_ALC_CHK;
                    end
                end
            end
            ST_REL_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_ALC_CHK:
            begin
                if (!status.byte_full || status.scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (op == OP_RELEASE)
                    begin
                        cmd.load_rel     = 1'b1;
                        cmd.emit_release = !status.rel_in_range;
                    end
                    else if (status.all_full)
                    begin
                        cmd.emit_full = 1'b1;
                    end
                    else
                    begin
                        cmd.load_alloc = 1'b1;
                    end
                end
            end
            ST_REL_WR:
            begin
                cmd.rel_write = 1'b1;
            end
            ST_ALC_CHK:
            begin
                if (!status.byte_full)
                begin
                    cmd.alc_hit = 1'b1;
                end
                else if (status.scan_last)
                begin
                    cmd.emit_full = 1'b1;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // At most one result source per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_release, cmd.rel_write, cmd.emit_full, cmd.alc_hit}))
        else $error("two result sources in one cycle");

    // A scan never runs past the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALC_CHK && status.scan_last && status.byte_full)
            |=> state_reg == ST_IDLE)
        else $error("scan went past the last byte");

endmodule

### rtl/core/bia_dp.sv
module bia_dp #(
    parameter int MAP_BYTES = bia_pkg::MAP_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bia_pkg::ID_W-1:0]  release_id,
    input  bia_pkg::cmd_t             cmd,
    output bia_pkg::status_t          status,
    output logic                      done,
    output logic [bia_pkg::ID_W-1:0]  granted_id,
    output logic                      map_full
);

    import bia_pkg::*;

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int HW = $clog2(MAP_BYTES + 1);

    logic [ID_W-1:0]   rel_id_reg;
    logic [ID_W-1:0]   rel_id_next;
    logic [AW-1:0]     scan_idx_reg;
    logic [AW-1:0]     scan_idx_next;
    logic [AW-1:0]     clr_idx_reg;
    logic [AW-1:0]     clr_idx_next;
    logic [HW-1:0]     hint_reg;
    logic [HW-1:0]     hint_next;
    logic              done_reg;
    logic              done_next;
    logic [ID_W-1:0]   granted_id_reg;
    logic [ID_W-1:0]   granted_id_next;
    logic              map_full_reg;
    logic              map_full_next;

    logic [31:0]       in_byte32;
    logic [31:0]       rel_byte32;
    logic [31:0]       hint32;
    logic [31:0]       scan32;
    logic [31:0]       clr32;
    logic [AW-1:0]     scan_inc;
    logic [BYTE_W-1:0] rd_data;
    logic [BYTE_W-1:0] set_mask;
    logic [BYTE_W-1:0] rel_mask;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;

    // Widen indexes for compares
    assign in_byte32  = 32'(release_id[ID_W-1:BIT_POS_W]);
    assign rel_byte32 = 32'(rel_id_reg[ID_W-1:BIT_POS_W]);
    assign hint32     = 32'(hint_reg);
    assign scan32     = 32'(scan_idx_reg);
    assign clr32      = 32'(clr_idx_reg);
    assign scan_inc   = scan_idx_reg + AW'(1);

    // Bit masks
    assign set_mask = lowest_clear(rd_data);
    assign rel_mask = BYTE_W'(1) << rel_id_reg[BIT_POS_W-1:0];

    // Status
    assign status.clr_last     = (clr32 == 32'(MAP_BYTES - 1));
    assign status.rel_in_range = (in_byte32 < 32'(MAP_BYTES));
    assign status.all_full     = (hint32 == 32'(MAP_BYTES));
    assign status.byte_full    = (rd_data == FULL_BYTE);
    assign status.scan_last    = (scan32 == 32'(MAP_BYTES - 1));

    // Select read address
    always_comb
    begin
        priority if (cmd.load_rel)
        begin
            rd_addr = in_byte32[AW-1:0];
        end
        else if (cmd.load_alloc)
        begin
            rd_addr = hint32[AW-1:0];
        end
        else
        begin
            rd_addr = scan_inc;
        end
    end

    // Select write
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_idx_reg;
        wr_data = '0;
        priority if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.rel_write)
        begin
            wr_en   = 1'b1;
            wr_addr = rel_byte32[AW-1:0];
            wr_data = rd_data & ~rel_mask;
        end
        else if (cmd.alc_hit)
        begin
            wr_en   = 1'b1;
            wr_addr = scan_idx_reg;
            wr_data = rd_data | set_mask;
        end
    end

    bia_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Advance indexes and hint, build result
    always_comb
    begin
        rel_id_next     = rel_id_reg;
        scan_idx_next   = scan_idx_reg;
        clr_idx_next    = clr_idx_reg;
        hint_next       = hint_reg;
        done_next       = 1'b0;
        granted_id_next = '0;
        map_full_next   = 1'b0;

        if (cmd.clear_step)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            hint_next    = '0;
        end
        if (cmd.load_rel)
        begin
            rel_id_next = release_id;
        end
        if (cmd.load_alloc)
        begin
            scan_idx_next = hint32[AW-1:0];
        end
        if (cmd.scan_step)
        begin
            scan_idx_next = scan_inc;
        end
        if (cmd.rel_write)
        begin
            done_next = 1'b1;
            if (rel_byte32 < hint32)
            begin
                hint_next = rel_byte32[HW-1:0];
            end
        end
        if (cmd.emit_release)
        begin
            done_next = 1'b1;
        end
        if (cmd.emit_full)
        begin
            done_next     = 1'b1;
            map_full_next = 1'b1;
            hint_next     = HW'(MAP_BYTES);
        end
        if (cmd.alc_hit)
        begin
            done_next       = 1'b1;
            granted_id_next = {scan32[BYTE_IDX_W-1:0], onehot_pos(set_mask)};
            hint_next       = scan32[HW-1:0];
        end
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            hint_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            clr_idx_reg <= clr_idx_next;
            hint_reg    <= hint_next;
            done_reg    <= done_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        rel_id_reg     <= rel_id_next;
        scan_idx_reg   <= scan_idx_next;
        granted_id_reg <= granted_id_next;
        map_full_reg   <= map_full_next;
    end

    assign done       = done_reg;
    assign granted_id = granted_id_reg;
    assign map_full   = map_full_reg;

    // Hint never points past the end of the map
    assert property (@(posedge clk) disable iff (!rst_n)
        hint32 <= 32'(MAP_BYTES))
        else $error("hint beyond map");

    // A full result always carries id zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && map_full_reg) |-> (granted_id_reg == '0))
        else $error("full result with nonzero id");

    // A grant only comes from a byte with room
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alc_hit |-> (rd_data != FULL_BYTE))
        else $error("grant from a full byte");

    // A grant is delivered as a non-full result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alc_hit |=> (done_reg && !map_full_reg))
        else $error("grant not delivered");

endmodule

### rtl/core/bitmap_id_allocator_top.sv
// Id allocator over a bitmap of MAP_BYTES bytes, one bit per id. After reset
// the block runs a clearing pass over every map byte with busy high. A request
// is taken when start is high and busy is low; its result shows on done,
// granted_id and map_full for exactly one cycle and cannot be held off. A hint
// register keeps the lowest byte that may still have a free bit, so an
// allocate reads the bitmap byte at the hint, then writes the update, and reads
// on through each full byte the scan walks past from the hint; the map RAM's
// single read port sets that pace at one byte per cycle. A release reads its
// byte, then writes it back; a release beyond the map, or an allocate while
// the map is known full, is answered without a map write. The result appears
// in the cycle in which busy has dropped again.
module bitmap_id_allocator_top #(
    parameter int MAP_BYTES = bia_pkg::MAP_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     op,
    input  logic [bia_pkg::ID_W-1:0] release_id,
    output logic                     busy,
    output logic                     done,
    output logic [bia_pkg::ID_W-1:0] granted_id,
    output logic                     map_full
);

    import bia_pkg::*;

    cmd_t    cmd;
    status_t status;

    bia_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    bia_dp #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .release_id (release_id),
        .cmd        (cmd),
        .status     (status),
        .done       (done),
        .granted_id (granted_id),
        .map_full   (map_full)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import bia_pkg::*;

    localparam int MAP_BYTES     = MAP_BYTES_DEF;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_COUNT  = 600;
    localparam int FILL_ALLOCS   = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 600;
    localparam int REPORT_LIMIT  = 10;
    localparam int ID_MAX        = (1 << ID_W) - 1;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] release_id;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            map_full;
    } grant_t;

    logic            clk        = 1'b0;
    logic            rst_n      = 1'b0;
    logic            start      = 1'b0;
    logic            op         = OP_ALLOC;
    logic [ID_W-1:0] release_id = '0;
    logic            busy;
    logic            done;
    logic [ID_W-1:0] granted_id;
    logic            map_full;

    // Pending requests, expected grants and the shadow bitmap
    request_t         pending_q[$];
    grant_t           grant_q[$];
    logic [BYTE_W-1:0] id_map [MAP_BYTES];

    // Idle control for the sender
    int unsigned idle_left = 0;
    logic        calm      = 1'b0;
    logic        quiet     = 1'b0;
    request_t    next_req;
    grant_t      predicted;
    grant_t      observed;
    grant_t      wanted;

    // Run bookkeeping
    int unsigned fail_cnt     = 0;
    int unsigned stall_cycles = 0;
    int unsigned n_alloc      = 0;
    int unsigned n_release    = 0;
    int unsigned n_full       = 0;
    int unsigned n_results    = 0;
    int          live_guess   = 0;

    bitmap_id_allocator_top #(
        .MAP_BYTES  (MAP_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .release_id (release_id),
        .busy       (busy),
        .done       (done),
        .granted_id (granted_id),
        .map_full   (map_full)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Apply one request to the shadow bitmap and return the grant it yields
    function automatic grant_t apply_request(input request_t req);
        grant_t      g;
        int unsigned byte_idx;
        g = '0;
        if (req.op == OP_RELEASE)
        begin
            byte_idx = req.release_id >> BIT_POS_W;
            if (byte_idx < MAP_BYTES)
            begin
                id_map[byte_idx][req.release_id[BIT_POS_W-1:0]] = 1'b0;
            end
            return g;
        end
        for (int i = 0; i < MAP_BYTES; i++)
        begin
            if (id_map[i] != FULL_BYTE)
            begin
                for (int b = 0; b < BYTE_W; b++)
                begin
                    if (!id_map[i][b])
                    begin
                        id_map[i][b] = 1'b1;
                        g.granted_id = ID_W'(i * BYTE_W + b);
                        return g;
                    end
                end
            end
        end
        g.map_full = 1'b1;
        return g;
    endfunction

    task automatic push_alloc();
        request_t req;
        req.op         = OP_ALLOC;
        req.release_id = ID_W'($urandom);
        pending_q.push_back(req);
        live_guess++;
    endtask

    task automatic push_release(input logic [ID_W-1:0] id);
        request_t req;
        req.op         = OP_RELEASE;
        req.release_id = id;
        pending_q.push_back(req);
        if (live_guess > 0)
        begin
            live_guess--;
        end
    endtask

    // Hold the sender off until every request has produced its grant
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || start || grant_q.size() != 0);
    endtask

    // Drive requests; predict the grant of each one the block takes
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            op         <= OP_ALLOC;
            release_id <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                predicted = apply_request('{op: op, release_id: release_id});
                grant_q.push_back(predicted);
                if (op == OP_ALLOC)
                begin
                    n_alloc++;
                end
                else
                begin
                    n_release++;
                end
            end
            if (start && busy)
            begin
                // hold the current request until the block takes it
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                if ($urandom_range(0, 63) == 0)
                begin
                    calm = ~calm;
                end
                if (!quiet && !calm && $urandom_range(0, 3) == 0)
                begin
                    idle_left = $urandom_range(1, 12) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    next_req = pending_q.pop_front();
                    start      <= 1'b1;
                    op         <= next_req.op;
                    release_id <= next_req.release_id;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Check each grant against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            observed = '{granted_id: granted_id, map_full: map_full};
            if (grant_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= REPORT_LIMIT)
                begin
                    $display("unexpected grant: id %0d full %0b", granted_id, map_full);
                end
            end
            else
            begin
                wanted = grant_q.pop_front();
                if (wanted.map_full)
                begin
                    n_full++;
                end
                if (observed.granted_id !== wanted.granted_id
                    || observed.map_full !== wanted.map_full)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_LIMIT)
                    begin
                        $display("grant %0d mismatch: expected id %0d full %0b, got id %0d full %0b",
                                 n_results, wanted.granted_id, wanted.map_full,
                                 observed.granted_id, observed.map_full);
                    end
                end
            end
        end
    end

    // Abort if neither a request nor a grant moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request or grant for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        foreach (id_map[i])
        begin
            id_map[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: id zero first, reuse of a freed id, byte crossing,
        // release of free ids at both ends of the id range
        push_alloc();
        push_alloc();
        push_alloc();
        push_release(12'd1);
        push_alloc();
        push_release(ID_W'(ID_MAX));
        push_release(12'd0);
        push_release(12'd0);
        push_alloc();
        repeat (8) push_alloc();
        push_release(12'h800);
        push_release(12'h7FF);
        push_release(12'd3);
        push_release(12'd9);
        push_alloc();
        push_alloc();
        wait_drained();

        // Random mix; releases mostly target the dense low range in use
        repeat (RANDOM_COUNT)
        begin
            if ($urandom_range(0, 99) < 55)
            begin
                push_alloc();
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                push_release(ID_W'($urandom_range(0, ID_MAX)));
            end
            else
            begin
                push_release(ID_W'($urandom_range(0, (live_guess + 7 > ID_MAX) ?
                                                  ID_MAX : live_guess + 7)));
            end
        end
        wait_drained();

        // Back to back with no idling: allocate, punch holes, allocate again
        quiet = 1'b1;
        repeat (FILL_ALLOCS) push_alloc();
        push_release(12'd0);
        push_release(ID_W'(ID_MAX));
        repeat (38) push_release(ID_W'($urandom_range(0, ID_MAX)));
        repeat (45) push_alloc();
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (grant_q.size() != 0)
        begin
            $display("%0d predicted grants never arrived", grant_q.size());
            fail_cnt += grant_q.size();
        end
        $display("Ran %0d requests (%0d allocates, %0d releases), %0d grants, %0d map-full",
                 n_alloc + n_release, n_alloc, n_release, n_results, n_full);
        $display("Failures counted: %0d", fail_cnt);
        if (fail_cnt == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
